### hw/rtl/swm_pkg.sv
// Shared constants, types and helpers for the sliding window maximum unit.
package swm_pkg;

    // Sizing of the candidate chain and the sample datapath.
    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int WS_WIDTH     = 7;
    localparam int AGE_WIDTH    = $clog2(WINDOW_MAX + 1);
    // One spare cell takes the new sample when the head has aged out of a full chain,
    // before the head shift compacts the chain again.
    localparam int CHAIN_LEN    = WINDOW_MAX + 1;

    typedef logic [AGE_WIDTH-1:0]           t_age;
    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [WS_WIDTH-1:0]            t_wsize;

    // Contents of one candidate cell. The age is the age the entry will
    // have at the next sample.
    typedef struct packed {
        logic    valid;
        t_age    age;
        t_sample value;
    } t_cell;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic    update;
        logic    shift;
        logic    start;
        t_age    size;
        t_sample sample;
    } t_cell_cmd;

    // Status of the chain seen by the controller.
    typedef struct packed {
        logic    any_valid;
        logic    head_valid;
        t_sample head_value;
    } t_chain_status;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_ALIGN = 2'b10
    } t_state;

    // Window sizes above WINDOW_MAX are clamped to WINDOW_MAX, the full window.
    function automatic t_age clamp_size(input t_wsize ws);
        t_age res;
        if (int'(ws) > WINDOW_MAX) begin
            res = AGE_WIDTH'(WINDOW_MAX);
        end else begin
            res = AGE_WIDTH'(ws);
        end
        return res;
    endfunction

endpackage

### hw/rtl/swm_ifaces.sv
// Valid/ready channel interfaces for samples and window maxima.

interface swm_sample_if;
    import swm_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_result_if;
    import swm_pkg::*;
    logic    valid;
    logic    ready;
    t_sample window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

### hw/rtl/sliding_window_maximum_unit.sv
// Sliding window maximum over a signed sample stream, built as a chain of deque cells.
//
//   Channel    Direction  Payload                      Transfer when
//   i_sample   in         sample[31:0], start_req      valid && ready
//   o_result   out        window_max[31:0]             valid && ready
//   i_cfg_*    in         window_size[6:0]             i_cfg_we
//
// Each sample is taken in, then the chain settles, then the head shifts past
// every aged-out entry, one cell at a time: normally none or one, up to
// WINDOW_MAX - 1 after the window is shrunk.
// Reset is synchronous and clears the cell valid flags at once; no clearing pass.
// A finished result waits in the output register while the next sample is taken;
// a stalled result only holds the chain when the next result is ready to load.
module sliding_window_maximum_unit
    import swm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    swm_sample_if.sink   i_sample,
    swm_result_if.source o_result,
    input  logic         i_cfg_we,
    input  t_wsize       i_cfg_wdata
);

    t_cell_cmd               cmd;
    t_chain_status           status;
    t_cell                   cells      [CHAIN_LEN];
    t_cell                   right_cell [CHAIN_LEN];
    logic [CHAIN_LEN-1:0]    keep_vec;
    logic [CHAIN_LEN-1:0]    valid_vec;
    logic [CHAIN_LEN-1:0]    left_keep;

    swm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_sample.valid),
        .o_in_ready   (i_sample.ready),
        .i_sample     (i_sample.sample),
        .i_start_req  (i_sample.start_req),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_out_valid  (o_result.valid),
        .i_out_ready  (o_result.ready),
        .o_window_max (o_result.window_max)
    );

    // Chain of cells: each sees its left neighbor's keep and its right neighbor's contents.
    for (genvar gi = 0; gi < CHAIN_LEN; gi++) begin : g_cell
        if (gi == CHAIN_LEN - 1) begin : g_last
            assign right_cell[gi] = '0;
        end else begin : g_mid
            assign right_cell[gi] = cells[gi+1];
        end

        if (gi == 0) begin : g_first
            assign left_keep[gi] = !(|keep_vec);
        end else begin : g_rest
            assign left_keep[gi] = keep_vec[gi-1];
        end

        swm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_left_keep  (left_keep[gi]),
            .i_right_cell (right_cell[gi]),
            .o_keep       (keep_vec[gi]),
            .o_cell       (cells[gi])
        );

        assign valid_vec[gi] = cells[gi].valid;
    end

    // Chain status for the controller.
    always_comb begin
        status.any_valid  = |valid_vec;
        status.head_valid = cells[0].valid;
        status.head_value = cells[0].value;
    end

endmodule

### hw/rtl/swm_cell.sv
// One candidate cell of the monotonic deque chain.
module swm_cell
    import swm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  logic      i_left_keep,
    input  t_cell     i_right_cell,
    output logic      o_keep,
    output t_cell     o_cell
);

    logic    r_valid;
    t_age    r_age;
    t_sample r_value;
    logic    n_valid;
    t_age    n_age;
    t_sample n_value;
    logic    load;

    // The entry survives if it beats the new sample, is still inside the window and no start is requested.
    assign o_keep = r_valid && !i_cmd.start
                    && ($signed(r_value) > $signed(i_cmd.sample))
                    && (r_age < i_cmd.size);

    // The first free cell after the survivors takes the new sample.
    assign load = !o_keep && i_left_keep;

    // Next contents: update on a new sample, shift toward the head while aligning.
    always_comb begin
        n_valid = r_valid;
        n_age   = r_age;
        n_value = r_value;
        if (i_cmd.update) begin
            if (o_keep) begin
                n_age = r_age + AGE_WIDTH'(1);
            end else if (load) begin
                n_valid = 1'b1;
                n_age   = AGE_WIDTH'(1);
                n_value = i_cmd.sample;
            end else begin
                n_valid = 1'b0;
            end
        end else if (i_cmd.shift) begin
            n_valid = i_right_cell.valid;
            n_age   = i_right_cell.age;
            n_value = i_right_cell.value;
        end
    end

    // Valid flag is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_age   <= n_age;
        r_value <= n_value;
    end

    assign o_cell = '{valid: r_valid, age: r_age, value: r_value};

endmodule

### hw/rtl/swm_ctrl.sv
// Sequencer, window register, sample counter and result register.
module swm_ctrl
    import swm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_sample       i_sample,
    input  logic          i_start_req,
    input  logic          i_cfg_we,
    input  t_wsize        i_cfg_wdata,
    input  t_chain_status i_status,
    output t_cell_cmd     o_cmd,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_sample       o_window_max
);

    t_state  r_state;
    t_state  n_state;
    t_wsize  r_window_size;
    t_age    r_seen;
    t_age    n_seen;
    logic    r_due;
    logic    r_out_valid;
    t_sample r_out_value;
    t_age    size;
    logic    accept;
    logic    aligned;
    logic    finish;

    assign size       = clamp_size(r_window_size);
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // The head is in cell 0 once the chain is compacted or empty.
    assign aligned = i_status.head_valid || !i_status.any_valid;
    assign finish  = (r_state == ST_ALIGN) && aligned
                     && (!r_due || !r_out_valid || i_out_ready);

    // Samples seen in the current stream, restarted by a start request.
    always_comb begin
        if (i_start_req) begin
            n_seen = AGE_WIDTH'(1);
        end else if (r_seen == AGE_WIDTH'(WINDOW_MAX)) begin
            n_seen = r_seen;
        end else begin
            n_seen = r_seen + AGE_WIDTH'(1);
        end
    end

    // Commands to the cell chain.
    always_comb begin
        o_cmd.update = accept;
        o_cmd.shift  = (r_state == ST_ALIGN) && !aligned;
        o_cmd.start  = i_start_req;
        o_cmd.size   = size;
        o_cmd.sample = i_sample;
    end

    // State sequencing.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_window_size <= WS_WIDTH'(1);
            r_seen        <= '0;
            r_due         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_window_size <= i_cfg_wdata;
            end
            if (accept) begin
                r_seen <= n_seen;
                r_due  <= (size != '0) && (n_seen >= size);
            end
            if (finish && r_due) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (finish && r_due) begin
            r_out_value <= i_status.head_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_value;

endmodule

### hw/rtl/swm_checker.sv
// Port-level checks for the sliding window maximum unit, bound to the top level.
module swm_checker
    import swm_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_sample i_window_max,
    input logic    i_cfg_we,
    input t_wsize  i_cfg_wdata
);

    t_wsize r_ws;

    // Shadow of the window size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= WS_WIDTH'(1);
        end else if (i_cfg_we) begin
            r_ws <= i_cfg_wdata;
        end
    end

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_window_max))
        else $error("window_max changed while stalled");

    // One sample at a time: the block is busy in the cycle after a transfer.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // A new result only appears while the block is working on a sample.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a sample in work");

    // A zero window gives no results.
    a_zero_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> r_ws != '0)
        else $error("result given with a zero window");

endmodule

bind sliding_window_maximum_unit swm_checker u_swm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_sample.valid),
    .i_in_ready   (i_sample.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_window_max (o_result.window_max),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_wdata  (i_cfg_wdata)
);
